/* sv/priority_ready_queue_scheduler_macros.svh */
// Assertion macros for the priority ready queue scheduler.
// Included by files that assert; expects clk and arst_n in scope.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, off while in reset
`define PRQS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define PRQS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/prqs_pkg.sv */
// Shared types and constants of the priority ready queue scheduler.
// No dependencies.
package prqs_pkg;

	localparam int ID_W       = 6;
	localparam int LINK_DEPTH = 64;
	localparam int LEVEL_W    = 6;

	localparam logic [LEVEL_W-1:0] NO_LEVEL = 6'd32;

	// request actions
	localparam logic [2:0] ACT_ADD_TAIL = 3'd0;
	localparam logic [2:0] ACT_SIGNAL   = 3'd1;
	localparam logic [2:0] ACT_KILL     = 3'd2;
	localparam logic [2:0] ACT_BLOCK    = 3'd3;
	localparam logic [2:0] ACT_PASS     = 3'd4;
	localparam logic [2:0] ACT_SCHEDULE = 3'd5;

	// task states reported with a result
	localparam logic [1:0] TS_READY   = 2'd0;
	localparam logic [1:0] TS_ACTIVE  = 2'd1;
	localparam logic [1:0] TS_BLOCKED = 2'd2;
	localparam logic [1:0] TS_ZOMBIE  = 2'd3;

	typedef struct packed {
		logic               any;
		logic [LEVEL_W-1:0] level;
	} enc_res_t;

endpackage

/* sv/prqs_enc.sv */
// Priority encoder over the level occupancy bitmap (bit 0 wins).
// Depends on prqs_pkg.
module prqs_enc
	import prqs_pkg::*;
#(
	parameter int NUM_LEVELS = 32
) (
	input  logic [NUM_LEVELS-1:0] occ,
	output enc_res_t              res
);

	logic [NUM_LEVELS-1:0] lowest;
	logic [LEVEL_W-1:0]    lvl;

	// isolate the lowest set bit, then OR its index in
	assign lowest = occ & (~occ + NUM_LEVELS'(1));

	always_comb begin
		lvl = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (lowest[i]) begin
				lvl = lvl | LEVEL_W'(i);
			end
		end
		res.any   = |occ;
		res.level = res.any ? lvl : NO_LEVEL;
	end

endmodule

/* sv/priority_ready_queue_scheduler.sv */
// Top level of the priority ready queue scheduler: per-level task FIFOs as linked lists.
// Depends on prqs_pkg, prqs_enc and priority_ready_queue_scheduler_macros.svh.
`include "priority_ready_queue_scheduler_macros.svh"

// Takes one request per clock: busy stays low and start may be held high every cycle.
// An accepted request is held in the request register (s1) and its result is then
// registered, shown for one cycle with done high; results come in request order and
// cannot be held off. The request register serves the 64-entry link store, whose
// read is launched at acceptance with the level head forwarded from the request in
// flight, so the link word is registered next to the request. Level heads, tails and
// links hold no reset value and need no clearing pass: only the occupancy bitmap,
// highest level, blocked count, s1 valid and done flag are reset: it is ready at once.
module priority_ready_queue_scheduler
	import prqs_pkg::*;
#(
	parameter int NUM_LEVELS = 32,
	parameter int MAX_TASKS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [5:0] task_id,
	input  logic [4:0] priority_req,
	output logic       done,
	output logic [5:0] selected_task,
	output logic       task_valid,
	output logic       wait_for_interrupt,
	output logic [5:0] top_level,
	output logic [1:0] new_task_state,
	output logic       status
);

	localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int BC_W  = $clog2(MAX_TASKS + 1);

	// state
	logic [ID_W-1:0]       level_head_q [NUM_LEVELS];
	logic [ID_W-1:0]       level_tail_q [NUM_LEVELS];
	logic [ID_W-1:0]       link_mem     [LINK_DEPTH];
	logic [NUM_LEVELS-1:0] occ_q;
	logic [LEVEL_W-1:0]    highest_q;
	logic [BC_W-1:0]       blocked_q;

	// request register plus prefetched head and link
	logic              vld_s1;
	logic [2:0]        act_s1;
	logic [ID_W-1:0]   task_s1;
	logic [LVL_W-1:0]  lvl_s1;
	logic [ID_W-1:0]   head_s1;
	logic [ID_W-1:0]   link_s1;

	// result register
	logic              done_q;
	logic [ID_W-1:0]   sel_q;
	logic              valid_q;
	logic              wfi_q;
	logic [LEVEL_W-1:0] top_q;
	logic [1:0]        state_q;
	logic              status_q;

	// update from the request in s1
	logic                  head_we;
	logic [ID_W-1:0]       head_wdata;
	logic                  tail_we;
	logic [ID_W-1:0]       tail_wdata;
	logic                  link_we;
	logic [ID_W-1:0]       link_waddr;
	logic [ID_W-1:0]       link_wdata;
	logic [NUM_LEVELS-1:0] occ_d;
	logic [BC_W-1:0]       blocked_d;
	logic [ID_W-1:0]       res_sel;
	logic                  res_valid;
	logic                  res_wfi;
	logic [1:0]            res_state;
	logic                  res_status;
	enc_res_t              enc;
	logic [LEVEL_W-1:0]    highest_d;

	// acceptance side
	logic              accept;
	logic [LVL_W-1:0]  lvl_in;
	logic [LVL_W-1:0]  rd_lvl;
	logic [ID_W-1:0]   head_fwd;
	logic [ID_W-1:0]   tail_rd;
	logic              occupied;
	logic [NUM_LEVELS-1:0] lvl_bit;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------------------------------------------------------
	// Acceptance: clamp the level, pick the head to prefetch. Schedule
	// wants the head of the highest level as it stands after the request
	// now in s1; the others want their own level. Both head and link are
	// forwarded from the s1 writes landing at the same edge.
	// ---------------------------------------------------------------
	always_comb begin
		if (int'(priority_req) >= NUM_LEVELS) begin
			lvl_in = LVL_W'(NUM_LEVELS - 1);
		end else begin
			lvl_in = LVL_W'(priority_req);
		end
		rd_lvl = (action == ACT_SCHEDULE) ? highest_d[LVL_W-1:0] : lvl_in;
		if (head_we && lvl_s1 == rd_lvl) begin
			head_fwd = head_wdata;
		end else begin
			head_fwd = level_head_q[rd_lvl];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= action;
			task_s1 <= task_id;
			lvl_s1  <= lvl_in;
			head_s1 <= head_fwd;
			// link store read, write-first on an address clash
			if (link_we && link_waddr == head_fwd) begin
				link_s1 <= link_wdata;
			end else begin
				link_s1 <= link_mem[head_fwd];
			end
		end
	end

	// ---------------------------------------------------------------
	// s1: one queue operation against the committed state. Tail and
	// occupancy are read here; head and its successor came prefetched.
	// ---------------------------------------------------------------
	assign tail_rd  = level_tail_q[lvl_s1];
	assign occupied = occ_q[lvl_s1];
	assign lvl_bit  = {{(NUM_LEVELS-1){1'b0}}, 1'b1} << lvl_s1;

	always_comb begin
		head_we    = 1'b0;
		head_wdata = task_s1;
		tail_we    = 1'b0;
		tail_wdata = task_s1;
		link_we    = 1'b0;
		link_waddr = tail_rd;
		link_wdata = task_s1;
		occ_d      = occ_q;
		blocked_d  = blocked_q;
		res_sel    = '0;
		res_valid  = 1'b0;
		res_wfi    = 1'b0;
		res_state  = TS_READY;
		res_status = 1'b0;
		if (vld_s1) begin
			case (act_s1)
				ACT_ADD_TAIL, ACT_SIGNAL: begin
					if (!occupied) begin
						// empty level: task becomes head and tail
						head_we = 1'b1;
						tail_we = 1'b1;
					end else if (act_s1 == ACT_ADD_TAIL) begin
						link_we = 1'b1;
						tail_we = 1'b1;
					end else begin
						// push in front of the old head
						link_we    = 1'b1;
						link_waddr = task_s1;
						link_wdata = head_s1;
						head_we    = 1'b1;
					end
					occ_d = occ_q | lvl_bit;
					if (act_s1 == ACT_SIGNAL && blocked_q != '0) begin
						blocked_d = blocked_q - BC_W'(1);
					end
					res_sel   = task_s1;
					res_valid = 1'b1;
				end
				ACT_KILL, ACT_BLOCK: begin
					if (!occupied) begin
						res_status = 1'b1;
					end else begin
						if (head_s1 == tail_rd) begin
							occ_d = occ_q & ~lvl_bit;
						end else begin
							head_we    = 1'b1;
							head_wdata = link_s1;
						end
						res_sel   = head_s1;
						res_valid = 1'b1;
						if (act_s1 == ACT_KILL) begin
							res_state = TS_ZOMBIE;
						end else begin
							res_state = TS_BLOCKED;
							if (blocked_q != BC_W'(MAX_TASKS)) begin
								blocked_d = blocked_q + BC_W'(1);
							end
						end
					end
				end
				ACT_PASS: begin
					if (!occupied) begin
						res_status = 1'b1;
					end else begin
						// single entry: order unchanged
						if (head_s1 != tail_rd) begin
							head_we    = 1'b1;
							head_wdata = link_s1;
							link_we    = 1'b1;
							link_wdata = head_s1;
							tail_we    = 1'b1;
							tail_wdata = head_s1;
						end
						res_sel   = head_s1;
						res_valid = 1'b1;
					end
				end
				ACT_SCHEDULE: begin
					if (|occ_q) begin
						res_sel   = head_s1;
						res_valid = 1'b1;
						res_state = TS_ACTIVE;
					end else if (blocked_q != '0) begin
						res_wfi = 1'b1;
					end
				end
				default: begin
					// unused codes leave everything as is
				end
			endcase
		end
	end

	// highest non-empty level after this request
	prqs_enc #(
		.NUM_LEVELS(NUM_LEVELS)
	) u_enc (
		.occ(occ_d),
		.res(enc)
	);

	assign highest_d = enc.level;

	// ---------------------------------------------------------------
	// Commit and result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			highest_q <= NO_LEVEL;
			blocked_q <= '0;
			done_q    <= 1'b0;
		end else begin
			occ_q     <= occ_d;
			highest_q <= highest_d;
			blocked_q <= blocked_d;
			done_q    <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			level_head_q[lvl_s1] <= head_wdata;
		end
		if (tail_we) begin
			level_tail_q[lvl_s1] <= tail_wdata;
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (vld_s1) begin
			sel_q    <= res_sel;
			valid_q  <= res_valid;
			wfi_q    <= res_wfi;
			top_q    <= highest_d;
			state_q  <= res_state;
			status_q <= res_status;
		end
	end

	assign done               = done_q;
	assign selected_task      = sel_q;
	assign task_valid         = valid_q;
	assign wait_for_interrupt = wfi_q;
	assign top_level          = top_q;
	assign new_task_state     = state_q;
	assign status             = status_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`PRQS_ASSERT_NXT(a_accept_done, vld_s1, done, "accepted request gave no result")
	`PRQS_ASSERT_IMP(a_top_consistent, 1'b1, (occ_q == '0) == (highest_q == NO_LEVEL), "highest level disagrees with bitmap")
	`PRQS_ASSERT_IMP(a_blocked_max, 1'b1, blocked_q <= BC_W'(MAX_TASKS), "blocked count past its limit")
	`PRQS_ASSERT_IMP(a_result_excl, done && task_valid, !wait_for_interrupt && !status, "valid task with wait or error flag")

endmodule
